// File: rtl/core/fca_pkg.sv
// Shared types and constants of the chain allocation table.
package fca_pkg;

    localparam int KIND_W  = 3;
    localparam int BLOCK_W = 16;
    localparam int STEPS_W = 16;
    localparam int RES_W   = 16;
    localparam int STAT_W  = 3;

    typedef enum logic [KIND_W-1:0] {
        K_FORMAT = 3'd0,
        K_NEW    = 3'd1,
        K_EXTEND = 3'd2,
        K_FREE   = 3'd3,
        K_END_AT = 3'd4,
        K_NEXT   = 3'd5,
        K_LENGTH = 3'd6,
        K_NTH    = 3'd7
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_RANGE   = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_PASTEND = 3'd3,
        ST_FREEENT = 3'd4,
        ST_LOOP    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_WALK,
        S_FREEW,
        S_SCAN,
        S_LINK,
        S_RESP
    } t_state;

endpackage

// File: rtl/core/fat_chain_allocator.sv
// Top level of the chain allocation table: sequencer around one table RAM.
//
// Keeps a table of TABLE_ENTRIES linked-block entries (ENTRY_BITS each; 0 ends a
// chain, all ones marks a free block) in one RAM with a registered read. One
// operation is in flight at a time and every operation returns exactly one result
// beat; the next operation beat is taken while an earlier result still waits on
// the output register. Each operation is paced by the single table read port, which
// serves one read per cycle: end-at and range rejects read no entry, next reads
// one, nth and length read the chain entries one at a time, new chain scans from
// entry 0 up to and including the first free one, extend reads along the chain and
// then scans, free chain reads every chain entry twice, and format is a write sweep;
// a result that finds the output register still full holds the sequencer in its
// response state until the register drains. After reset a clearing pass marks every
// entry free; no operation is accepted until it ends. Walks stop after TABLE_ENTRIES
// links with a loop status.
module fat_chain_allocator
    import fca_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int ENTRY_BITS    = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [BLOCK_W+STEPS_W-1:0] s_axis_tdata,  // block[15:0], steps[31:16]
    input  logic [KIND_W-1:0]         s_axis_tuser,  // kind[2:0]
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [RES_W-1:0]          m_axis_tdata,  // result_block[15:0]
    output logic [STAT_W-1:0]         m_axis_tuser   // status[2:0]
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [31:0] TE32 = 32'(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] CNT_CAP = CW'(TABLE_ENTRIES);
    localparam logic [ENTRY_BITS-1:0] FREE_MARK = '1;

    // control state
    t_state              r_state, n_state;
    t_kind               r_kind, n_kind;
    logic                r_fmt_resp, n_fmt_resp;   // sweep ends with a result beat
    logic [IW-1:0]       r_chk, n_chk;             // sweep / scan index
    logic [CW-1:0]       r_cnt, n_cnt;             // links followed
    logic [IW-1:0]       r_cur, n_cur;             // entry whose word is on q
    logic [IW-1:0]       r_blk, n_blk;
    logic [IW-1:0]       r_tail, n_tail;
    logic [STEPS_W-1:0]  r_steps, n_steps;
    logic [RES_W-1:0]    r_res, n_res;
    t_status             r_st, n_st;
    logic                r_o_valid;
    logic [RES_W-1:0]    r_o_res;
    t_status             r_o_st;

    // table port
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [ENTRY_BITS-1:0] ram_wdata;
    logic [IW-1:0]         ram_raddr;
    logic [ENTRY_BITS-1:0] q;

    logic                accept;
    logic                load_out;
    t_kind               in_kind;
    logic [BLOCK_W-1:0]  in_block;
    logic [STEPS_W-1:0]  in_steps;
    logic                in_oor;
    logic                q_free, q_zero, q_big;
    logic [CW-1:0]       cnt_nx;

    fca_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(q)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign in_kind  = t_kind'(s_axis_tuser);
    assign in_block = s_axis_tdata[BLOCK_W-1:0];
    assign in_steps = s_axis_tdata[BLOCK_W+STEPS_W-1:BLOCK_W];
    assign in_oor   = (32'(in_block) >= TE32);

    assign q_free = (q == FREE_MARK);
    assign q_zero = (q == '0);
    assign q_big  = (32'(q) >= TE32);
    assign cnt_nx = r_cnt + CW'(1);

    assign load_out = (r_state == S_RESP) && (!r_o_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_SWEEP;
            r_fmt_resp <= 1'b0;
            r_chk      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fmt_resp <= n_fmt_resp;
            r_chk      <= n_chk;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_cnt   <= n_cnt;
        r_cur   <= n_cur;
        r_blk   <= n_blk;
        r_tail  <= n_tail;
        r_steps <= n_steps;
        r_res   <= n_res;
        r_st    <= n_st;
        if (load_out) begin
            r_o_res <= r_res;
            r_o_st  <= r_st;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_fmt_resp = r_fmt_resp;
        n_chk      = r_chk;
        n_cnt      = r_cnt;
        n_cur      = r_cur;
        n_blk      = r_blk;
        n_tail     = r_tail;
        n_steps    = r_steps;
        n_res      = r_res;
        n_st       = r_st;
        ram_we     = 1'b0;
        ram_waddr  = r_chk;
        ram_wdata  = FREE_MARK;
        ram_raddr  = r_cur;

        unique case (r_state)
            S_SWEEP: begin
                // reset clear or format: one entry per cycle
                ram_we    = 1'b1;
                ram_waddr = r_chk;
                if (r_fmt_resp && r_chk == IW'(0)) begin
                    ram_wdata = ENTRY_BITS'(1);
                end else if (r_fmt_resp && r_chk == IW'(1)) begin
                    ram_wdata = '0;
                end else begin
                    ram_wdata = FREE_MARK;
                end
                if (r_chk == LAST_IDX) begin
                    n_chk = '0;
                    if (r_fmt_resp) begin
                        n_res   = '0;
                        n_st    = ST_OK;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_chk = r_chk + IW'(1);
                end
            end

            S_IDLE: begin
                if (accept) begin
                    n_kind  = in_kind;
                    n_steps = in_steps;
                    n_blk   = IW'(in_block);
                    n_cur   = IW'(in_block);
                    n_cnt   = '0;
                    n_res   = '0;
                    n_st    = ST_OK;
                    unique case (in_kind)
                        K_FORMAT: begin
                            n_chk      = '0;
                            n_fmt_resp = 1'b1;
                            n_state    = S_SWEEP;
                        end
                        K_NEW: begin
                            ram_raddr = '0;
                            n_chk     = '0;
                            n_state   = S_SCAN;
                        end
                        K_EXTEND, K_FREE: begin
                            if (in_block == '0 || in_oor) begin
                                n_st    = ST_RANGE;
                                n_state = S_RESP;
                            end else begin
                                ram_raddr = IW'(in_block);
                                n_state   = S_WALK;
                            end
                        end
                        K_END_AT: begin
                            if (in_oor) begin
                                n_st = ST_RANGE;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = IW'(in_block);
                                ram_wdata = '0;
                            end
                            n_state = S_RESP;
                        end
                        K_NEXT, K_LENGTH: begin
                            if (in_oor) begin
                                n_st    = ST_RANGE;
                                n_state = S_RESP;
                            end else begin
                                ram_raddr = IW'(in_block);
                                n_state   = S_WALK;
                            end
                        end
                        K_NTH: begin
                            if (in_steps == '0) begin
                                // zero links: the block itself, unchecked
                                n_res   = RES_W'(in_block);
                                n_state = S_RESP;
                            end else if (in_oor) begin
                                n_st    = ST_RANGE;
                                n_state = S_RESP;
                            end else begin
                                ram_raddr = IW'(in_block);
                                n_state   = S_WALK;
                            end
                        end
                    endcase
                end
            end

            S_WALK: begin
                unique case (r_kind)
                    K_NEXT: begin
                        if (q_free) begin
                            n_st = ST_FREEENT;
                        end else begin
                            n_res = RES_W'(q);
                        end
                        n_state = S_RESP;
                    end
                    K_NTH: begin
                        if (q_free) begin
                            n_st    = ST_FREEENT;
                            n_state = S_RESP;
                        end else if (q_zero) begin
                            n_st    = ST_PASTEND;
                            n_state = S_RESP;
                        end else if (32'(cnt_nx) == 32'(r_steps)) begin
                            n_res   = RES_W'(q);
                            n_state = S_RESP;
                        end else if (cnt_nx == CNT_CAP) begin
                            n_st    = ST_LOOP;
                            n_state = S_RESP;
                        end else if (q_big) begin
                            n_st    = ST_RANGE;
                            n_state = S_RESP;
                        end else begin
                            n_cnt     = cnt_nx;
                            n_cur     = IW'(q);
                            ram_raddr = IW'(q);
                        end
                    end
                    default: begin
                        // length, extend, free: find the last block
                        if (q_free) begin
                            n_st    = ST_FREEENT;
                            n_state = S_RESP;
                        end else if (q_zero) begin
                            if (r_kind == K_LENGTH) begin
                                n_res   = RES_W'(r_cnt);
                                n_state = S_RESP;
                            end else if (r_kind == K_EXTEND) begin
                                n_tail    = r_cur;
                                n_chk     = '0;
                                ram_raddr = '0;
                                n_state   = S_SCAN;
                            end else begin
                                // chain checked: walk it again, freeing entries
                                n_cur     = r_blk;
                                ram_raddr = r_blk;
                                n_state   = S_FREEW;
                            end
                        end else if (cnt_nx == CNT_CAP) begin
                            n_st    = ST_LOOP;
                            n_state = S_RESP;
                        end else if (q_big) begin
                            n_st    = ST_RANGE;
                            n_state = S_RESP;
                        end else begin
                            n_cnt     = cnt_nx;
                            n_cur     = IW'(q);
                            ram_raddr = IW'(q);
                        end
                    end
                endcase
            end

            S_FREEW: begin
                // chain is acyclic, so the write never hits the read address
                ram_we    = 1'b1;
                ram_waddr = r_cur;
                ram_wdata = FREE_MARK;
                if (r_cnt == '0) begin
                    n_state = S_RESP;
                end else begin
                    n_cnt     = r_cnt - CW'(1);
                    n_cur     = IW'(q);
                    ram_raddr = IW'(q);
                end
            end

            S_SCAN: begin
                if (q_free) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_chk;
                    ram_wdata = '0;
                    n_res     = RES_W'(r_chk);
                    n_state   = (r_kind == K_EXTEND) ? S_LINK : S_RESP;
                end else if (r_chk == LAST_IDX) begin
                    n_st    = ST_NOSPACE;
                    n_state = S_RESP;
                end else begin
                    n_chk     = r_chk + IW'(1);
                    ram_raddr = r_chk + IW'(1);
                end
            end

            S_LINK: begin
                ram_we    = 1'b1;
                ram_waddr = r_tail;
                ram_wdata = ENTRY_BITS'(r_chk);
                n_state   = S_RESP;
            end

            S_RESP: begin
                if (load_out) begin
                    n_fmt_resp = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_res;
    assign m_axis_tuser  = r_o_st;

    // a failed operation always reports block zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("error result with nonzero block");

    // the table is never written while the sequencer waits for work
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !accept) |-> !ram_we)
        else $error("table write while idle");

    // a new result beat only ever comes from the response state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_RESP))
        else $error("result beat without a finished operation");

    // the clearing pass after reset gives no result beat
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && !r_fmt_resp && r_chk == LAST_IDX) |=> (r_state == S_IDLE))
        else $error("clearing pass did not return to idle");

endmodule

// File: rtl/core/fca_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module fca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule
